FILE: hw/rtl/u8lev_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package u8lev_pkg;
    localparam int MAX_LEN = 96;
    localparam int CNT_W = 7;
    localparam int IDX_W = 7;
    localparam int CP_W = 21;
    localparam int DIST_W = 7;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_SECOND = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    // sequence length from lead byte; 1 for ASCII, continuation or invalid lead
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd1;
        if ((b & 8'hE0) == 8'hC0) n = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) n = 3'd4;
        return n;
    endfunction

    function automatic logic [CP_W-1:0] compose(input logic [31:0] p, input logic [2:0] n);
        logic [CP_W-1:0] cp;
        case (n)
            3'd2: cp = {10'd0, p[4:0], p[13:8]};
            3'd3: cp = {5'd0, p[3:0], p[13:8], p[21:16]};
            3'd4: cp = {p[2:0], p[13:8], p[21:16], p[29:24]};
            default: cp = {13'd0, p[7:0]};
        endcase
        return cp;
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/utf8_levenshtein_distance_core.sv
// Byte beats (mode 0/1): one per cycle while idle, no result. One compute in flight at a time.
// Compute to result valid: flush both strings, decide, row seed (blen+1 entries),
// then per DP cell a row read, then a compute and write back. An empty string
// or too_long skips the row seed and cells.
// Result held in the output register until taken; input stalls meanwhile.
// Sync reset (i_rst_n low) clears counts, pending byte counts and FSM; memories are read-first.
`timescale 1ns / 1ps
`default_nettype none
module utf8_levenshtein_distance_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0] s_axis_tuser,   // [1:0] mode
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] distance, [7] zero
    output logic            m_axis_tuser    // [0] too_long
);
    import u8lev_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FLUSH = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_INIT = 3'd3;
    localparam logic [2:0] ST_CELL = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;

    logic [2:0] r_state;
    logic [CNT_W-1:0] r_cnt [2];
    logic [2:0] r_pc [2];
    logic [31:0] r_pend [2];
    logic r_fs;          // string being flushed
    logic [2:0] r_fi;    // flush position

    // code point memories
    logic [CP_W-1:0] mem_a [MAX_LEN];
    logic [CP_W-1:0] mem_b [MAX_LEN];
    // one DP row, updated in place; left and diagonal kept in registers
    logic [DIST_W-1:0] mem_row [MAX_LEN+1];

    logic [IDX_W-1:0] r_i, r_j;
    logic [DIST_W-1:0] r_left, r_diag;
    logic [CP_W-1:0] r_ai, r_bj;
    logic [DIST_W-1:0] r_up;
    logic r_rd;          // read data for cell j valid this cycle
    logic [DIST_W-1:0] r_dist;
    logic r_long;

    // ---- emit logic (byte path and flush path share it) ----
    logic em_v, em_s;
    logic [CP_W-1:0] em_cp;
    logic [7:0] b;
    logic s;
    logic [2:0] pc, n0, fn;
    logic [31:0] npend;
    logic [7:0] fb;
    logic [31:0] fsh;

    assign b = s_axis_tdata;
    assign s = s_axis_tuser[0];
    assign s_axis_tready = (r_state == ST_IDLE);
    wire acc = s_axis_tvalid && s_axis_tready;
    wire byte_acc = acc && (s_axis_tuser == MODE_FIRST || s_axis_tuser == MODE_SECOND);
    wire cmp_acc = acc && s_axis_tuser == MODE_COMPUTE;

    assign fsh = r_pend[r_fs] >> {r_fi, 3'b000};
    assign fb = fsh[7:0];
    always_comb begin
        pc = r_pc[s];
        npend = r_pend[s];
        n0 = seq_len(npend[7:0]);
        fn = seq_len(fb);
        if ({1'b0, r_fi} + {1'b0, fn} > {1'b0, r_pc[r_fs]}) fn = 3'd1;
        em_v = 1'b0;
        em_s = s;
        em_cp = '0;
        if (r_state == ST_FLUSH) begin
            em_s = r_fs;
            em_v = (r_fi < r_pc[r_fs]);
            em_cp = compose(fsh, fn);
        end else if (byte_acc && b != 8'd0 && r_cnt[s] <= CNT_W'(MAX_LEN)) begin
            if (pc == 3'd0) begin
                if (seq_len(b) == 3'd1) begin
                    em_v = 1'b1;
                    em_cp = {13'd0, b};
                end
            end else begin
                npend[{pc[1:0], 3'b000} +: 8] = b;
                if (pc + 3'd1 >= n0) begin
                    em_v = 1'b1;
                    em_cp = compose(npend, pc + 3'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_v && r_cnt[em_s] < CNT_W'(MAX_LEN)) begin
            if (em_s) mem_b[r_cnt[em_s]] <= em_cp;
            else mem_a[r_cnt[em_s]] <= em_cp;
        end
        if (byte_acc && b != 8'd0 && r_cnt[s] <= CNT_W'(MAX_LEN))
            r_pend[s] <= (pc == 3'd0) ? {24'd0, b} : npend;
    end

    // ---- DP walk ----
    wire [IDX_W-1:0] alen = r_cnt[0];
    wire [IDX_W-1:0] blen = r_cnt[1];
    wire [DIST_W-1:0] cost = (r_ai == r_bj) ? '0 : DIST_W'(1);
    logic [DIST_W-1:0] c1, c2, dp_val;
    always_comb begin
        c1 = (r_up < r_left) ? r_up + 1'b1 : r_left + 1'b1;
        c2 = r_diag + cost;
        dp_val = (c2 < c1) ? c2 : c1;
    end

    always_ff @(posedge i_clk) begin
        r_ai <= mem_a[r_i[IDX_W-1:0] - 1'b1];
        r_bj <= mem_b[r_j - 1'b1];
        r_up <= mem_row[r_j];
        if (r_state == ST_INIT) mem_row[r_j] <= DIST_W'(r_j);
        else if (r_state == ST_CELL && r_rd) mem_row[r_j] <= dp_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt[0] <= '0; r_cnt[1] <= '0;
            r_pc[0] <= '0; r_pc[1] <= '0;
            m_axis_tvalid <= 1'b0;
            r_fs <= 1'b0; r_fi <= '0; r_rd <= 1'b0;
        end else begin
            if (em_v && r_cnt[em_s] <= CNT_W'(MAX_LEN)) r_cnt[em_s] <= r_cnt[em_s] + 1'b1;
            unique case (r_state)
                ST_IDLE: begin
                    if (byte_acc && b != 8'd0 && r_cnt[s] <= CNT_W'(MAX_LEN)) begin
                        if (pc == 3'd0) r_pc[s] <= (seq_len(b) == 3'd1) ? 3'd0 : 3'd1;
                        else if (em_v) r_pc[s] <= 3'd0;
                        else r_pc[s] <= (pc > 3'd3) ? 3'd4 : pc + 3'd1;
                    end
                    if (cmp_acc) begin
                        r_state <= ST_FLUSH; r_fs <= 1'b0; r_fi <= '0;
                    end
                end
                ST_FLUSH: begin
                    if (em_v) r_fi <= r_fi + fn;
                    else begin
                        r_pc[r_fs] <= '0; r_fi <= '0;
                        if (r_fs) r_state <= ST_DECIDE;
                        r_fs <= 1'b1;
                    end
                end
                ST_DECIDE: begin
                    r_long <= 1'b0;
                    if (alen == '0 || blen == '0) begin
                        r_dist <= alen | blen; r_state <= ST_OUT;
                    end else if (alen > IDX_W'(MAX_LEN) || blen > IDX_W'(MAX_LEN)) begin
                        r_dist <= '0; r_long <= 1'b1; r_state <= ST_OUT;
                    end else begin
                        r_j <= '0; r_state <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    if (r_j == blen) begin
                        r_i <= IDX_W'(1); r_j <= IDX_W'(1);
                        r_left <= DIST_W'(1); r_diag <= '0; r_rd <= 1'b0;
                        r_state <= ST_CELL;
                    end else r_j <= r_j + 1'b1;
                end
                ST_CELL: begin
                    // cycle A: addresses presented (r_rd=0); cycle B: compute and write
                    r_rd <= ~r_rd;
                    if (r_rd) begin
                        if (r_j == blen) begin
                            if (r_i == alen) begin
                                r_dist <= dp_val; r_state <= ST_DONE;
                            end else begin
                                r_i <= r_i + 1'b1; r_j <= IDX_W'(1);
                                r_left <= DIST_W'(r_i) + 1'b1; r_diag <= DIST_W'(r_i);
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_diag <= r_up;
                            r_left <= dp_val;
                        end
                    end
                end
                ST_DONE: r_state <= ST_OUT;
                ST_OUT: begin
                    if (!m_axis_tvalid) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata <= {1'b0, r_dist};
                        m_axis_tuser <= r_long;
                        r_cnt[0] <= '0; r_cnt[1] <= '0;
                    end else if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_cnt_cap0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CNT_W'(MAX_LEN + 1)) else $error("count over cap");
    a_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0) else $error("too_long with distance");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
endmodule
`default_nettype wire
